// ===== hw/rtl/z85_pkg.sv =====
// Shared types, constants and the character map of the Z85 byte encoder.
// No dependencies; the pack, queue, back-end and top-level files refer to it by scoped name.
package z85_pkg;

	// One closed group of four bytes on its way from the front to the back end
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} grp_t;

	localparam int Z85_FIFO_DEPTH = 2;
	localparam int Z85_GROUP_CHARS = 5;

	// floor(x / 85) == (x * Z85_MAGIC) >> Z85_SHIFT for every 32-bit x
	localparam logic [31:0] Z85_MAGIC = 32'hC0C0C0C1;
	localparam int Z85_SHIFT = 38;

	localparam logic [8*85-1:0] Z85_ALPHABET =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

	// Map a base-85 digit to its ASCII character; first character sits in the top byte
	function automatic logic [7:0] z85_char(input logic [6:0] digit);
		logic [9:0] pos;
		pos = 10'(8 * (84 - int'(digit)));
		if (digit > 7'd84) begin
			z85_char = 8'h30;
		end else begin
			z85_char = Z85_ALPHABET[pos +: 8];
		end
	endfunction

endpackage

// ===== hw/rtl/z85_pack.sv =====
// Front end: accepts bytes, gathers them big-endian and closes groups.
// Depends on z85_pkg (grp_t).
module z85_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	output logic              push_valid,
	input  logic              push_ready,
	output z85_pkg::grp_t     push_data
);

	logic [23:0] acc_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        close;

	assign s_tready = push_ready;
	assign accept   = s_tvalid && s_tready;
	assign close    = (cnt_q == 2'd3) || s_tlast;

	// Left-align the group; missing low bytes pad with zero
	always_comb begin
		case (cnt_q)
			2'd0:    push_data.word = {s_tdata, 24'd0};
			2'd1:    push_data.word = {acc_q[7:0], s_tdata, 16'd0};
			2'd2:    push_data.word = {acc_q[15:0], s_tdata, 8'd0};
			default: push_data.word = {acc_q, s_tdata};
		endcase
		push_data.last = s_tlast;
	end

	assign push_valid = accept && close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (close) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= {acc_q[15:0], s_tdata};
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/z85_fifo.sv =====
// Short group queue between the front and back ends.
// Depends on z85_pkg (grp_t).
module z85_fifo #(
	parameter int DEPTH = z85_pkg::Z85_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  z85_pkg::grp_t     in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output z85_pkg::grp_t     out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	z85_pkg::grp_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/z85_back.sv =====
// Back end: splits a group word into five base-85 digits and streams the characters.
// Depends on z85_pkg (grp_t, divide-by-85 constants, character map).
module z85_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  z85_pkg::grp_t     pop_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [2:0] LAST_STEP = 3'(z85_pkg::Z85_GROUP_CHARS - 1);

	logic [1:0]  cst_q;
	logic [2:0]  step_q;
	logic [31:0] x_q;
	logic [31:0] q_q;
	logic [6:0]  dig_q [z85_pkg::Z85_GROUP_CHARS];
	logic        last_q;

	logic        ebusy_q;
	logic [2:0]  eidx_q;
	logic [6:0]  ebuf_q [z85_pkg::Z85_GROUP_CHARS];
	logic        elast_q;

	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	logic [31:0] mul_in;
	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] q85;
	logic [31:0] diff;
	logic [6:0]  rem;
	logic        take;
	logic        out_load;

	assign pop_ready = (cst_q == ST_IDLE);

	// One multiply per cycle; its product is registered in q_q before reuse
	assign mul_in = (cst_q == ST_IDLE) ? pop_data.word : q_q;
	assign prod   = {32'd0, mul_in} * {32'd0, z85_pkg::Z85_MAGIC};
	assign quo    = 32'(prod[63:z85_pkg::Z85_SHIFT]);

	assign q85  = (q_q << 6) + (q_q << 4) + (q_q << 2) + q_q;
	assign diff = x_q - q85;
	assign rem  = diff[6:0];

	assign take     = (cst_q == ST_DONE) && !ebusy_q;
	assign out_load = ebusy_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= ST_IDLE;
			step_q <= '0;
		end else begin
			unique case (cst_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cst_q  <= ST_RUN;
						step_q <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						cst_q <= ST_DONE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (take) begin
						cst_q <= ST_IDLE;
					end
				end
				default: cst_q <= ST_IDLE;
			endcase
		end
	end

	// Digits come out least significant first
	always_ff @(posedge clk) begin
		if (cst_q == ST_IDLE) begin
			if (pop_valid) begin
				x_q    <= pop_data.word;
				q_q    <= quo;
				last_q <= pop_data.last;
			end
		end else if (cst_q == ST_RUN) begin
			dig_q[step_q] <= rem;
			x_q           <= q_q;
			q_q           <= quo;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ebuf_q  <= dig_q;
			elast_q <= last_q;
		end
		if (out_load) begin
			m_tdata_q <= z85_pkg::z85_char(ebuf_q[LAST_STEP - eidx_q]);
			m_tuser_q <= (eidx_q == LAST_STEP);
			m_tlast_q <= (eidx_q == LAST_STEP) && elast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ebusy_q    <= 1'b0;
			eidx_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				ebusy_q <= 1'b1;
				eidx_q  <= '0;
			end else if (out_load) begin
				if (eidx_q == LAST_STEP) begin
					ebusy_q <= 1'b0;
				end else begin
					eidx_q <= eidx_q + 3'd1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== hw/rtl/z85_byte_encoder_core.sv =====
// Z85 byte encoder, top level: byte stream in, Z85 character stream out.
// Depends on z85_pkg, z85_pack, z85_fifo and z85_back.
//
// Usage
//   Slave side: one message byte per request in s_tdata; s_tlast marks the final
//   byte of a message and closes the group, padding missing low bytes with zeros.
//   Master side: one ASCII character per request in m_tdata; m_tuser is set on
//   the fifth character of each group, m_tlast on the fifth character of the
//   group that a final byte closed.
//   Path: a closed group passes through the queue and the digit unit into the
//   character buffer, whose five characters leave one a cycle while m_tready
//   is high. Group rate is set by the digit unit, which loads a group, runs five
//   divide-by-85 steps on its single multiplier and hands the digits over, and
//   takes no new group from the queue until the hand-over is done.
//   Bytes that do not close a group are taken every cycle while the queue has room.
//   Reset: arst_n clears the byte gatherer, the queue and both stream stages;
//   no character is pending afterwards.
//   Stall: m_tready held low freezes the output register; the digit buffer and
//   the group queue then fill, and s_tready drops only once the queue is full.
module z85_byte_encoder_core #(
	parameter int FIFO_DEPTH = z85_pkg::Z85_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tuser,   // [0] group_last
	output logic       m_tlast
);

	logic          push_valid;
	logic          push_ready;
	z85_pkg::grp_t push_data;
	logic          pop_valid;
	logic          pop_ready;
	z85_pkg::grp_t pop_data;

	// Gather bytes and hand each closed group to the queue
	z85_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Hold closed groups so the front keeps taking bytes while the back is busy
	z85_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	// Convert each group to five characters, most significant digit first
	z85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hw/rtl/z85_check.sv =====
// Port-level checks on the output stream of the Z85 byte encoder.
// Depends on nothing; bound to z85_byte_encoder_core below.
module z85_check (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// Message end always falls on a group end
	a_msg_on_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("message end off a group boundary");

	// Every character lies in the printable range of the alphabet
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >= 8'h21) && (m_tdata <= 8'h7d))
		else $error("character outside the alphabet range");

	// A stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled request changed");

	// Nothing is pending straight out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("request pending after reset");

endmodule

bind z85_byte_encoder_core z85_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== verif/tb.sv =====
// Self-checking bench for z85_byte_encoder_core: byte requests in, Z85 characters out.
// Depends on z85_pkg and the encoder RTL only; predicts every character from its own model.
module tb;

	typedef struct packed {
		logic [7:0] ch;
		logic       grp_end;
		logic       msg_end;
	} z85_char_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_BURSTY
	} rx_mode_t;

	// Character map of the encoding, first character in the top byte
	localparam logic [8*85-1:0] CHAR_MAP =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
	localparam int unsigned TOP_WEIGHT = 85 * 85 * 85 * 85;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 24;
	localparam int RANDOM_BYTES = 230;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	// Model state: bytes gathered in the open group
	logic [31:0] gather_word = '0;
	logic [1:0]  gather_count = '0;
	z85_char_t   pending_chars[$];

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_hold = 0;
	bit       tx_idle = 1'b0;
	int       burst_left = 0;

	int errors = 0;
	int bytes_sent = 0;
	int messages_sent = 0;
	int short_groups = 0;
	int chars_checked = 0;

	z85_byte_encoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Take one accepted byte into the model; queue five characters when a group closes
	task automatic predict_group(input logic [7:0] b, input logic fin);
		int unsigned held;
		int unsigned word;
		int unsigned weight;
		int unsigned digit;
		z85_char_t   c;
		held = int'(gather_count) + 1;
		gather_word = {gather_word[23:0], b};
		if (held < 4 && !fin) begin
			gather_count = held[1:0];
			return;
		end
		if (held < 4) begin
			short_groups++;
		end
		// Pad the missing low bytes with zeros
		word = gather_word << (8 * (4 - held));
		weight = TOP_WEIGHT;
		for (int k = 0; k < 5; k++) begin
			digit = (word / weight) % 85;
			c.ch = CHAR_MAP[8 * (84 - digit) +: 8];
			c.grp_end = (k == 4);
			c.msg_end = (k == 4) && fin;
			pending_chars.push_back(c);
			weight = weight / 85;
		end
		gather_word = '0;
		gather_count = '0;
	endtask

	// Offer one byte, hold it until taken, then predict; call at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (tx_idle && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			s_tlast <= 1'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		predict_group(b, fin);
		bytes_sent++;
		if (fin) begin
			messages_sent++;
		end
	endtask

	task automatic send_message(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b, i == len - 1);
		end
	endtask

	// Receiver stall pattern, kept apart from the sender's bursts
	always @(posedge clk) begin
		case (rx_mode)
			RX_OPEN: begin
				m_tready <= 1'b1;
			end
			RX_RANDOM: begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (rx_hold == 0) begin
					m_tready <= ~m_tready;
					rx_hold = $urandom_range(1, 8);
				end else begin
					rx_hold--;
				end
			end
		endcase
	end

	// Compare every character taken with the oldest one predicted
	always @(posedge clk) begin
		z85_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character: got ch=%02h grp=%b msg=%b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (m_tdata !== want.ch) begin
					$display("%0t: out_char mismatch: expected %02h, actual %02h",
						$time, want.ch, m_tdata);
					errors++;
				end
				if (m_tuser !== want.grp_end) begin
					$display("%0t: group_last mismatch: expected %b, actual %b",
						$time, want.grp_end, m_tuser);
					errors++;
				end
				if (m_tlast !== want.msg_end) begin
					$display("%0t: message_last mismatch: expected %b, actual %b",
						$time, want.msg_end, m_tlast);
					errors++;
				end
			end
		end
	end

	// Full groups at the extremes and a known eight-byte vector closed on a fourth byte
	task automatic test_known_vectors();
		logic [7:0] hello[8] = '{8'h86, 8'h4F, 8'hD2, 8'h6F, 8'hB5, 8'h59, 8'hF7, 8'h5B};
		for (int i = 0; i < 4; i++) begin
			send_byte(8'h00, 1'b0);
		end
		for (int i = 0; i < 4; i++) begin
			send_byte(8'hFF, i == 3);
		end
		for (int i = 0; i < 8; i++) begin
			send_byte(hello[i], i == 7);
		end
	endtask

	// Final flag on the first, second and third byte of a group
	task automatic test_short_groups();
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Random messages, mostly short, a few long, with idling on both sides
	task automatic test_random_messages();
		int target;
		target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_message($urandom_range(1, 4));
				3, 4, 5, 6: send_message($urandom_range(5, 12));
				7, 8: send_message($urandom_range(13, 40));
				default: send_message(1);
			endcase
			if ($urandom_range(0, 7) == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				tx_idle = $urandom_range(0, 3) != 0;
			end
		end
	endtask

	initial begin
		int guard;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_mode = RX_OPEN;
		tx_idle = 1'b0;
		test_known_vectors();
		rx_mode = RX_BURSTY;
		tx_idle = 1'b1;
		test_short_groups();
		rx_mode = RX_RANDOM;
		test_random_messages();
		s_tvalid <= 1'b0;

		// Drain the characters still owed, then watch for strays
		rx_mode = RX_RANDOM;
		guard = 0;
		while (pending_chars.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, pending_chars.size());
			errors++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d messages (%0d short final groups), %0d chars checked.",
			bytes_sent, messages_sent, short_groups, chars_checked);
		$display("Receiver ran open, random and bursty; sender ran back to back and in bursts.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
